>>> src/rpse_pkg.sv
package rpse_pkg;

    // default store depth
    localparam int CAPACITY = 64;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int RND_W   = 31;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_GETRND = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic              start;
        logic              search;
        logic              ins;
        logic              rd_last;
        logic              move;
        logic              div_step;
        logic              fetch;
        logic              load_out;
        logic [STAT_W-1:0] status;
        logic              use_rd;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              cnt_zero;
        logic              cnt_full;
        logic              search_end;
        logic              found;
        logic              div_done;
        logic              out_free;
    } t_stat;

endpackage

>>> src/rpse_ctrl.sv
module rpse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rpse_pkg::t_stat  i_st,
    output rpse_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_LAST   = 3'd3;
    localparam logic [2:0] S_MOVE   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FETCH  = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0]                   r_state, n_state;
    logic [rpse_pkg::STAT_W-1:0]  r_status, n_status;
    logic                         r_use_rd, n_use_rd;

    // state and pending result code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= rpse_pkg::ST_OK;
            r_use_rd <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_use_rd <= n_use_rd;
        end
    end

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_use_rd = r_use_rd;
        o_cmd    = '0;
        o_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_use_rd = 1'b0;
                n_status = rpse_pkg::ST_OK;
                case (i_st.func) inside
                    rpse_pkg::FN_INSERT, rpse_pkg::FN_REMOVE: begin
                        n_state = S_SEARCH;
                    end
                    rpse_pkg::FN_GETRND: begin
                        if (i_st.cnt_zero) begin
                            n_status = rpse_pkg::ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_st.search_end) begin
                    if (i_st.func == rpse_pkg::FN_INSERT) begin
                        n_state = S_RESP;
                        if (i_st.found) begin
                            n_status = rpse_pkg::ST_MISS;
                        end else if (i_st.cnt_full) begin
                            n_status = rpse_pkg::ST_FULL;
                        end else begin
                            o_cmd.ins = 1'b1;
                            n_status  = rpse_pkg::ST_OK;
                        end
                    end else if (i_st.found) begin
                        n_state = S_LAST;
                    end else begin
                        n_status = rpse_pkg::ST_MISS;
                        n_state  = S_RESP;
                    end
                end
            end
            S_LAST: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_status   = rpse_pkg::ST_OK;
                n_state    = S_RESP;
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    n_state = S_FETCH;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_status    = rpse_pkg::ST_OK;
                n_use_rd    = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                o_cmd.status = r_status;
                o_cmd.use_rd = r_use_rd;
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/rpse_dp.sv
module rpse_dp #(
    parameter int CAPACITY = rpse_pkg::CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rpse_pkg::t_cmd                i_cmd,
    output rpse_pkg::t_stat               o_st,
    input  logic [rpse_pkg::FUNC_W-1:0]   i_func,
    input  logic [rpse_pkg::VALUE_W-1:0]  i_value,
    input  logic [rpse_pkg::RND_W-1:0]    i_rnd,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [rpse_pkg::STAT_W-1:0]   o_m_status,
    output logic [rpse_pkg::VALUE_W-1:0]  o_m_value,
    output logic [rpse_pkg::COUNT_W-1:0]  o_m_count
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = (CW > rpse_pkg::COUNT_W) ? CW : rpse_pkg::COUNT_W;
    localparam int RW  = rpse_pkg::RND_W;
    localparam int DCW = $clog2(RW + 1);

    // value store
    logic [rpse_pkg::VALUE_W-1:0] r_mem [CAPACITY];
    logic [rpse_pkg::VALUE_W-1:0] r_rdata;

    // request fields
    logic [rpse_pkg::FUNC_W-1:0]  r_func;
    logic [rpse_pkg::VALUE_W-1:0] r_val;

    // live count and search state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_sidx;
    logic [AW-1:0] r_pidx;
    logic [AW-1:0] r_pos;
    logic          r_pend;
    logic          r_found;

    // remainder unit
    logic [CW-1:0]  r_rem;
    logic [RW-1:0]  r_dvd;
    logic [DCW-1:0] r_dcnt;

    // output slot
    logic                          r_ovld;
    logic [rpse_pkg::STAT_W-1:0]   r_ostat;
    logic [rpse_pkg::VALUE_W-1:0]  r_oval;
    logic [rpse_pkg::COUNT_W-1:0]  r_ocnt;

    logic                          w_issue;
    logic                          w_hit;
    logic                          w_rd_en;
    logic [AW-1:0]                 w_raddr;
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [rpse_pkg::VALUE_W-1:0]  w_wdata;
    logic [CW-1:0]                 w_last;
    logic [CW:0]                   w_trial;
    logic [CW:0]                   w_diff;
    logic [XW-1:0]                 w_cnt_x;

    assign w_issue = i_cmd.search && !r_found && (r_sidx < r_count);
    assign w_hit   = i_cmd.search && r_pend && !r_found && (r_rdata == r_val);
    assign w_last  = r_count - CW'(1);
    assign w_trial = {r_rem, r_dvd[RW-1]};
    assign w_diff  = w_trial - {1'b0, r_count};
    assign w_cnt_x = XW'(r_count);

    // read port select
    always_comb begin
        w_rd_en = w_issue || i_cmd.rd_last || i_cmd.fetch;
        if (i_cmd.rd_last) begin
            w_raddr = w_last[AW-1:0];
        end else if (i_cmd.fetch) begin
            w_raddr = r_rem[AW-1:0];
        end else begin
            w_raddr = r_sidx[AW-1:0];
        end
    end

    // write port select
    always_comb begin
        w_we = i_cmd.ins || i_cmd.move;
        if (i_cmd.move) begin
            w_waddr = r_pos;
            w_wdata = r_rdata;
        end else begin
            w_waddr = r_count[AW-1:0];
            w_wdata = r_val;
        end
    end

    // store access
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_cmd.ins) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.move) begin
                r_count <= w_last;
            end
            if (i_cmd.start) begin
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.search) begin
                r_pend <= w_issue;
                if (w_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func <= i_func;
            r_val  <= i_value;
            r_sidx <= '0;
            r_rem  <= '0;
            r_dvd  <= i_rnd;
            r_dcnt <= '0;
        end else begin
            if (w_issue) begin
                r_sidx <= r_sidx + CW'(1);
                r_pidx <= r_sidx[AW-1:0];
            end
            if (w_hit) begin
                r_pos <= r_pidx;
            end
            // one quotient bit a step
            if (i_cmd.div_step) begin
                r_dvd  <= {r_dvd[RW-2:0], 1'b0};
                r_dcnt <= r_dcnt + DCW'(1);
                if (!w_diff[CW]) begin
                    r_rem <= w_diff[CW-1:0];
                end else begin
                    r_rem <= w_trial[CW-1:0];
                end
            end
        end
        if (i_cmd.load_out) begin
            r_ostat <= i_cmd.status;
            r_oval  <= i_cmd.use_rd ? r_rdata : '0;
            r_ocnt  <= w_cnt_x[rpse_pkg::COUNT_W-1:0];
        end
    end

    // status to controller
    always_comb begin
        o_st.func       = r_func;
        o_st.cnt_zero   = (r_count == '0);
        o_st.cnt_full   = (r_count == CW'(CAPACITY));
        o_st.search_end = r_found || (!r_pend && (r_sidx >= r_count));
        o_st.found      = r_found;
        o_st.div_done   = (r_dcnt == DCW'(RW));
        o_st.out_free   = !r_ovld || i_m_tready;
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_status = r_ostat;
    assign o_m_value  = r_oval;
    assign o_m_count  = r_ocnt;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("live count above capacity");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |-> (r_count < CW'(CAPACITY)))
        else $error("append into a full store");

    a_move_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move |-> (r_found && (r_count != '0)))
        else $error("slot move without a hit");

    a_pos_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && i_cmd.search) |-> (CW'(r_pos) < r_count))
        else $error("hit position outside live entries");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_ovld)
        else $error("result not presented after load");
`endif

endmodule

>>> src/random_pick_set_engine_top.sv
// channel   | dir | tdata (low bit up)                   | tuser
// s_axis    | in  | value[31:0], random_word[62:32], pad | func[1:0]
// m_axis    | out | value_out[31:0], count[38:32], pad   | status[1:0]
//
// insert and remove first search the store, reading one live entry a cycle
// through its single read port; a remove then moves the last entry to the hit
// slot in S_LAST and S_MOVE. get random runs the 31-step bit-serial remainder unit.
// one request is in work at a time; the next is taken while a result waits in the
// output register, and its result is held until the earlier one is taken.
// i_rst_n is synchronous, active low; it clears the count, the store is not cleared.
module random_pick_set_engine_top #(
    parameter int CAPACITY = rpse_pkg::CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // value, random_word, zero pad
    input  logic [1:0]  i_s_axis_tuser,  // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // value_out, count, zero pad
    output logic [1:0]  o_m_axis_tuser   // status
);

    rpse_pkg::t_cmd  w_cmd;
    rpse_pkg::t_stat w_st;

    logic [rpse_pkg::VALUE_W-1:0] w_oval;
    logic [rpse_pkg::COUNT_W-1:0] w_ocnt;

    // sequencer
    rpse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    // store, search, remainder and output slot
    rpse_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_func     (i_s_axis_tuser),
        .i_value    (i_s_axis_tdata[31:0]),
        .i_rnd      (i_s_axis_tdata[62:32]),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_status (o_m_axis_tuser),
        .o_m_value  (w_oval),
        .o_m_count  (w_ocnt)
    );

    assign o_m_axis_tdata = {1'b0, w_ocnt, w_oval};

endmodule
